@@ hdl/wget_pkg.sv @@
// Shared types, codes and constants for the weighted graph edge table.
// No dependencies; used by wget_ctrl, wget_dpath and the top level.
`default_nettype none

package wget_pkg;

    // Default sizing, used as the defaults of the top level parameters
    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 16;

    // Fixed field widths of the stream items and configuration port
    localparam int CMD_W         = 3;
    localparam int VERTEX_W      = 6;
    localparam int IN_WEIGHT_W   = 16;
    localparam int EDGE_WEIGHT_W = 17;
    localparam int COUNT_W       = 13;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 40;
    localparam int M_TUSER_W     = 2;
    localparam int CFG_ADDR_W    = 1;
    localparam int CFG_DATA_W    = 7;

    localparam logic [CFG_DATA_W-1:0]           VCOUNT_RESET = 7'd64;
    localparam logic [COUNT_W-1:0]              TOTAL_MAX    = 13'd8191;
    localparam logic signed [EDGE_WEIGHT_W-1:0] NO_EDGE      = -17'sd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_QUERY  = 3'd2,
        CMD_DEGREE = 3'd3,
        CMD_LIST   = 3'd4,
        CMD_COUNT  = 3'd5
    } t_cmd;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DIRECTED     = 1'd0,
        REG_VERTEX_COUNT = 1'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_MOD1,
        ST_MOD2,
        ST_RESP,
        ST_LIST,
        ST_LIST_END
    } t_state;

    typedef enum logic [3:0] {
        RES_DONE,
        RES_ERR,
        RES_REMOVE,
        RES_QUERY,
        RES_DEGREE,
        RES_TOTAL,
        RES_NB,
        RES_NB_LAST,
        RES_EMPTY
    } t_res;

    typedef struct packed {
        logic                             status;
        logic                             found;
        logic signed [EDGE_WEIGHT_W-1:0]  edge_weight;
        logic [COUNT_W-1:0]               count;
        logic [VERTEX_W-1:0]              neighbor;
        logic                             last;
    } t_result;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr_wr;     // zero one row of present bits and its degree
        logic take_in;    // capture an input transfer
        logic rd_src;     // read row, degree and weight at the source vertex
        logic mod_src;    // update the source row, total and hit flag
        logic rd_dst;     // read row and degree at the destination vertex
        logic upd_dst;    // write the mirrored entry
        logic list_load;  // load the row scanner
        logic list_step;  // advance the row scanner by one vertex
        logic res_load;   // load the output register
        t_res res_sel;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_done;
        t_cmd cmd;
        logic bad_vertex;
        logic had_now;
        logic mirror;
        logic out_free;
        logic scan_bit;
        logic scan_last;
        logic pend_valid;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hdl/wget_ctrl.sv @@
// Controller state machine for the weighted graph edge table.
// Depends on wget_pkg; drives wget_dpath through command and status structs.
`default_nettype none

module wget_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire wget_pkg::t_dp_stat i_stat,
    output wget_pkg::t_dp_cmd       o_cmd
);

    wget_pkg::t_state r_state;
    wget_pkg::t_state n_state;
    logic             list_emit;
    logic             list_stall;

    // A found neighbor pushes out the held one; stall while the output is full
    assign list_emit  = i_stat.scan_bit && i_stat.pend_valid;
    assign list_stall = list_emit && !i_stat.out_free;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wget_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wget_pkg::ST_CLEAR: begin
                if (i_stat.clr_done) n_state = wget_pkg::ST_IDLE;
            end
            wget_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = wget_pkg::ST_CHECK;
            end
            wget_pkg::ST_CHECK: begin
                case (i_stat.cmd)
                    wget_pkg::CMD_COUNT: n_state = wget_pkg::ST_RESP;
                    wget_pkg::CMD_ADD, wget_pkg::CMD_REMOVE, wget_pkg::CMD_QUERY,
                    wget_pkg::CMD_DEGREE, wget_pkg::CMD_LIST: begin
                        n_state = i_stat.bad_vertex ? wget_pkg::ST_RESP : wget_pkg::ST_MOD1;
                    end
                    default: n_state = wget_pkg::ST_IDLE;
                endcase
            end
            wget_pkg::ST_MOD1: begin
                case (i_stat.cmd)
                    wget_pkg::CMD_ADD: begin
                        n_state = i_stat.mirror ? wget_pkg::ST_MOD2 : wget_pkg::ST_RESP;
                    end
                    wget_pkg::CMD_REMOVE: begin
                        n_state = (i_stat.mirror && i_stat.had_now) ? wget_pkg::ST_MOD2
                                                                    : wget_pkg::ST_RESP;
                    end
                    wget_pkg::CMD_LIST: n_state = wget_pkg::ST_LIST;
                    default:            n_state = wget_pkg::ST_RESP;
                endcase
            end
            wget_pkg::ST_MOD2: n_state = wget_pkg::ST_RESP;
            wget_pkg::ST_RESP: begin
                if (i_stat.out_free) n_state = wget_pkg::ST_IDLE;
            end
            wget_pkg::ST_LIST: begin
                if (!list_stall && i_stat.scan_last) n_state = wget_pkg::ST_LIST_END;
            end
            wget_pkg::ST_LIST_END: begin
                if (i_stat.out_free) n_state = wget_pkg::ST_IDLE;
            end
            default: n_state = wget_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.res_sel = wget_pkg::RES_DONE;
        case (r_state)
            wget_pkg::ST_CLEAR: o_cmd.clr_wr = 1'b1;
            wget_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.take_in = i_in_valid;
            end
            wget_pkg::ST_CHECK: begin
                o_cmd.rd_src = !i_stat.bad_vertex;
            end
            wget_pkg::ST_MOD1: begin
                o_cmd.mod_src   = 1'b1;
                o_cmd.list_load = (i_stat.cmd == wget_pkg::CMD_LIST);
                o_cmd.rd_dst    = i_stat.mirror &&
                                  ((i_stat.cmd == wget_pkg::CMD_ADD) ||
                                   ((i_stat.cmd == wget_pkg::CMD_REMOVE) && i_stat.had_now));
            end
            wget_pkg::ST_MOD2: o_cmd.upd_dst = 1'b1;
            wget_pkg::ST_RESP: begin
                o_cmd.res_load = i_stat.out_free;
                if (i_stat.cmd == wget_pkg::CMD_COUNT) begin
                    o_cmd.res_sel = wget_pkg::RES_TOTAL;
                end else if (i_stat.bad_vertex) begin
                    o_cmd.res_sel = wget_pkg::RES_ERR;
                end else begin
                    case (i_stat.cmd)
                        wget_pkg::CMD_REMOVE: o_cmd.res_sel = wget_pkg::RES_REMOVE;
                        wget_pkg::CMD_QUERY:  o_cmd.res_sel = wget_pkg::RES_QUERY;
                        wget_pkg::CMD_DEGREE: o_cmd.res_sel = wget_pkg::RES_DEGREE;
                        default:              o_cmd.res_sel = wget_pkg::RES_DONE;
                    endcase
                end
            end
            wget_pkg::ST_LIST: begin
                o_cmd.list_step = !list_stall;
                o_cmd.res_load  = list_emit && i_stat.out_free;
                o_cmd.res_sel   = wget_pkg::RES_NB;
            end
            wget_pkg::ST_LIST_END: begin
                o_cmd.res_load = i_stat.out_free;
                o_cmd.res_sel  = i_stat.pend_valid ? wget_pkg::RES_NB_LAST
                                                   : wget_pkg::RES_EMPTY;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/wget_dpath.sv @@
// Datapath of the weighted graph edge table: row, degree and weight memories,
// edge total, row scanner and output register. Depends on wget_pkg.
`default_nettype none

module wget_dpath #(
    parameter int MAX_VERTICES = wget_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = wget_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire wget_pkg::t_dp_cmd                   i_cmd,
    output wget_pkg::t_dp_stat                       o_stat,
    input  wire logic [wget_pkg::S_TDATA_W-1:0]      i_in_data,
    input  wire logic                                i_cfg_we,
    input  wire logic [wget_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [wget_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output wget_pkg::t_result                        o_out
);

    localparam int VW         = $clog2(MAX_VERTICES);
    localparam int DEG_W      = $clog2(MAX_VERTICES + 1);
    localparam int WMEM_DEPTH = 1 << (2 * VW);
    localparam logic [VW-1:0] LAST_V = VW'(MAX_VERTICES - 1);

    // Configuration registers
    logic                                r_directed;
    logic [wget_pkg::CFG_DATA_W-1:0]     r_vcount;

    // Captured input item
    logic [wget_pkg::CMD_W-1:0]          r_cmd;
    logic [wget_pkg::VERTEX_W-1:0]       r_src;
    logic [wget_pkg::VERTEX_W-1:0]       r_dst;
    logic [WEIGHT_BITS-1:0]              r_wt;

    // Memories and their registered read data
    logic [MAX_VERTICES-1:0]             r_row_mem [0:MAX_VERTICES-1];
    logic [DEG_W-1:0]                    r_deg_mem [0:MAX_VERTICES-1];
    logic [WEIGHT_BITS-1:0]              r_wt_mem  [0:WMEM_DEPTH-1];
    logic [MAX_VERTICES-1:0]             r_rd_row;
    logic [DEG_W-1:0]                    r_rd_deg;
    logic [WEIGHT_BITS-1:0]              r_rd_wt;

    logic [wget_pkg::COUNT_W-1:0]        r_total;
    logic                                r_had;
    logic [VW-1:0]                       r_clr_idx;

    // Row scanner
    logic [MAX_VERTICES-1:0]             r_scan_row;
    logic [VW-1:0]                       r_scan;
    logic [VW-1:0]                       r_pend;
    logic                                r_pend_valid;

    logic                                r_out_valid;
    wget_pkg::t_result                   r_out;

    wget_pkg::t_cmd                      cmd_e;
    logic [VW-1:0]                       s_idx;
    logic [VW-1:0]                       d_idx;
    logic                                src_ok;
    logic                                dst_ok;
    logic                                uses_dst;
    logic                                is_add;
    logic                                is_rem;
    logic                                had_now;
    logic                                mir_bit;
    logic                                rd_en;
    logic [VW-1:0]                       rd_addr;
    logic                                row_we;
    logic [VW-1:0]                       row_waddr;
    logic [MAX_VERTICES-1:0]             row_wdata;
    logic [DEG_W-1:0]                    deg_wdata;
    logic                                wt_we;
    logic [2*VW-1:0]                     wt_waddr;
    logic                                out_free;
    wget_pkg::t_result                   res;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_directed <= 1'b0;
            r_vcount   <= wget_pkg::VCOUNT_RESET;
        end else if (i_cfg_we) begin
            case (wget_pkg::t_cfg_reg'(i_cfg_addr))
                wget_pkg::REG_DIRECTED:     r_directed <= i_cfg_wdata[0];
                wget_pkg::REG_VERTEX_COUNT: r_vcount   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Capture the input transfer: cmd [2:0], src [8:3], dst [14:9], weight [30:15]
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_cmd <= i_in_data[2:0];
            r_src <= i_in_data[8:3];
            r_dst <= i_in_data[14:9];
            r_wt  <= WEIGHT_BITS'(i_in_data[30:15]);
        end
    end

    // Decode and range check
    assign cmd_e    = wget_pkg::t_cmd'(r_cmd);
    assign s_idx    = VW'(r_src);
    assign d_idx    = VW'(r_dst);
    assign src_ok   = ({1'b0, r_src} < r_vcount) && (int'(r_src) < MAX_VERTICES);
    assign dst_ok   = ({1'b0, r_dst} < r_vcount) && (int'(r_dst) < MAX_VERTICES);
    assign uses_dst = (cmd_e == wget_pkg::CMD_ADD) || (cmd_e == wget_pkg::CMD_REMOVE) ||
                      (cmd_e == wget_pkg::CMD_QUERY);
    assign is_add   = (cmd_e == wget_pkg::CMD_ADD);
    assign is_rem   = (cmd_e == wget_pkg::CMD_REMOVE);
    assign had_now  = r_rd_row[d_idx];
    assign mir_bit  = r_rd_row[s_idx];

    // Memory reads, one port each
    assign rd_en   = i_cmd.rd_src || i_cmd.rd_dst;
    assign rd_addr = i_cmd.rd_dst ? d_idx : s_idx;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_row <= r_row_mem[rd_addr];
            r_rd_deg <= r_deg_mem[rd_addr];
        end
        if (i_cmd.rd_src) begin
            r_rd_wt <= r_wt_mem[{s_idx, d_idx}];
        end
    end

    // Row and degree write data: clear sweep, source update or mirrored update
    always_comb begin
        row_we    = 1'b0;
        row_waddr = s_idx;
        row_wdata = r_rd_row;
        deg_wdata = r_rd_deg;
        if (i_cmd.clr_wr) begin
            row_we    = 1'b1;
            row_waddr = r_clr_idx;
            row_wdata = '0;
            deg_wdata = '0;
        end else if (i_cmd.mod_src) begin
            row_we           = is_add || (is_rem && had_now);
            row_waddr        = s_idx;
            row_wdata[d_idx] = is_add;
            if (is_add && !had_now) begin
                deg_wdata = r_rd_deg + DEG_W'(1);
            end else if (is_rem && had_now && (r_rd_deg != '0)) begin
                deg_wdata = r_rd_deg - DEG_W'(1);
            end
        end else if (i_cmd.upd_dst) begin
            row_we           = is_add || is_rem;
            row_waddr        = d_idx;
            row_wdata[s_idx] = is_add;
            if (is_add && !mir_bit) begin
                deg_wdata = r_rd_deg + DEG_W'(1);
            end else if (is_rem && mir_bit && (r_rd_deg != '0)) begin
                deg_wdata = r_rd_deg - DEG_W'(1);
            end
        end
    end

    assign wt_we    = is_add && (i_cmd.mod_src || i_cmd.upd_dst);
    assign wt_waddr = i_cmd.upd_dst ? {d_idx, s_idx} : {s_idx, d_idx};

    // Memory writes
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            r_row_mem[row_waddr] <= row_wdata;
            r_deg_mem[row_waddr] <= deg_wdata;
        end
        if (wt_we) begin
            r_wt_mem[wt_waddr] <= r_wt;
        end
    end

    // Clear sweep index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_idx <= r_clr_idx + VW'(1);
        end
    end

    // Edge total, saturating at both ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.mod_src) begin
            if (is_add && !had_now && (r_total != wget_pkg::TOTAL_MAX)) begin
                r_total <= r_total + wget_pkg::COUNT_W'(1);
            end else if (is_rem && had_now && (r_total != '0)) begin
                r_total <= r_total - wget_pkg::COUNT_W'(1);
            end
        end
    end

    // Hold the hit flag of the source entry for the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_src) begin
            r_had <= had_now;
        end
    end

    // Row scanner: shift the row down one vertex a step, hold the last neighbor seen
    always_ff @(posedge i_clk) begin
        if (i_cmd.list_load) begin
            r_scan_row <= r_rd_row;
            r_scan     <= '0;
        end else if (i_cmd.list_step) begin
            r_scan_row <= r_scan_row >> 1;
            r_scan     <= r_scan + VW'(1);
            if (r_scan_row[0]) begin
                r_pend <= r_scan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.list_load) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.list_step && r_scan_row[0]) begin
            r_pend_valid <= 1'b1;
        end
    end

    // Result assembly
    always_comb begin
        res      = '0;
        res.last = 1'b1;
        case (i_cmd.res_sel)
            wget_pkg::RES_DONE:   ;
            wget_pkg::RES_ERR:    res.status = 1'b1;
            wget_pkg::RES_REMOVE: res.found  = r_had;
            wget_pkg::RES_QUERY: begin
                res.found       = r_had;
                res.edge_weight = r_had ? signed'(wget_pkg::EDGE_WEIGHT_W'(r_rd_wt))
                                        : wget_pkg::NO_EDGE;
            end
            wget_pkg::RES_DEGREE: res.count = wget_pkg::COUNT_W'(r_rd_deg);
            wget_pkg::RES_TOTAL:  res.count = r_total;
            wget_pkg::RES_NB: begin
                res.found    = 1'b1;
                res.neighbor = wget_pkg::VERTEX_W'(r_pend);
                res.last     = 1'b0;
            end
            wget_pkg::RES_NB_LAST: begin
                res.found    = 1'b1;
                res.neighbor = wget_pkg::VERTEX_W'(r_pend);
            end
            wget_pkg::RES_EMPTY:  ;
            default: ;
        endcase
    end

    // Output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Status to the controller
    assign o_stat.clr_done   = (r_clr_idx == LAST_V);
    assign o_stat.cmd        = cmd_e;
    assign o_stat.bad_vertex = !src_ok || (uses_dst && !dst_ok);
    assign o_stat.had_now    = had_now;
    assign o_stat.mirror     = !r_directed && (r_src != r_dst);
    assign o_stat.out_free   = out_free;
    assign o_stat.scan_bit   = r_scan_row[0];
    assign o_stat.scan_last  = (r_scan == LAST_V);
    assign o_stat.pend_valid = r_pend_valid;

endmodule

`default_nettype wire

@@ hdl/weighted_graph_edge_table_core.sv @@
// Input transfer to result: edge count and range errors pass ST_CHECK and ST_RESP; add,
// remove, weight query and degree also pass ST_MOD1, and an undirected add, or undirected remove
// of a present edge, between two different vertices also passes ST_MOD2 before ST_RESP.
// One item at a time: no new transfer until the result of the last one is loaded; a reserved code
// gives no result. A neighbor listing walks one vertex of the row per cycle while not stalled.
// Reset: synchronous, active low; a clearing pass then zeroes one row of present
// bits and its degree per cycle, over all MAX_VERTICES rows, before the first transfer.
`default_nettype none

module weighted_graph_edge_table_core #(
    parameter int MAX_VERTICES = wget_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = wget_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: cmd [2:0], src_vertex [8:3], dst_vertex [14:9], weight [30:15], zero [31]
    input  wire logic [wget_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // Result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata: edge_weight [16:0], count [29:17], neighbor [35:30], zero [39:36]
    output logic [wget_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    // tuser: status [0], found [1]
    output logic [wget_pkg::M_TUSER_W-1:0]         m_axis_tuser,
    output logic                                   m_axis_tlast,
    // Configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [wget_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [wget_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    wget_pkg::t_dp_cmd  dp_cmd;
    wget_pkg::t_dp_stat dp_stat;
    wget_pkg::t_result  out_res;

    wget_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    wget_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (out_res)
    );

    // Pack the result fields onto the stream
    assign m_axis_tdata = {{(wget_pkg::M_TDATA_W - 36){1'b0}},
                           out_res.neighbor, out_res.count, out_res.edge_weight};
    assign m_axis_tuser = {out_res.found, out_res.status};
    assign m_axis_tlast = out_res.last;

`ifndef SYNTHESIS
    // No transfer is taken in the cycle after a reset edge: the clearing pass runs first
    a_clear_first: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready during clearing pass");

    // A result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.res_load |-> dp_stat.out_free)
        else $error("result loaded over a waiting result");

    // One item at a time: no input transfer right after another
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    // Memory writes of a mirrored entry only follow a source update
    a_mirror_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.upd_dst |-> $past(dp_cmd.mod_src))
        else $error("mirrored write without source update");
`endif

endmodule

`default_nettype wire

@@ dv/wget_edge_table_checker.sv @@
// Checker for the weighted graph edge table: watches the command, result and register channels.
// It keeps its own copy of the graph and compares each result transfer with the oldest one due.
// Depends on wget_pkg for the command codes, register indexes and the result layout.
`timescale 1ns / 100ps

module wget_edge_table_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    // tdata: cmd [2:0], src_vertex [8:3], dst_vertex [14:9], weight [30:15], zero [31]
    input  wire logic [wget_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata: edge_weight [16:0], count [29:17], neighbor [35:30], zero [39:36]
    input  wire logic [wget_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // tuser: status [0], found [1]
    input  wire logic [wget_pkg::M_TUSER_W-1:0]    m_axis_tuser,
    input  wire logic                              m_axis_tlast,
    input  wire logic                              i_cfg_we,
    input  wire logic [wget_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [wget_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output int                                     o_results_due,
    output int                                     o_fail_count
);

    localparam int NV = wget_pkg::MAX_VERTICES_DEF;

    // Graph copy and register copy
    logic                               edge_on    [NV][NV];
    logic [wget_pkg::IN_WEIGHT_W-1:0]   edge_wt    [NV][NV];
    logic [6:0]                         row_degree [NV];
    logic [wget_pkg::COUNT_W-1:0]       edge_total;
    logic                               mode_directed;
    logic [wget_pkg::CFG_DATA_W-1:0]    vertices_used;

    wget_pkg::t_result                  due_results [$];

    function automatic wget_pkg::t_result result_of(input logic st, input logic fnd,
                                  input logic signed [wget_pkg::EDGE_WEIGHT_W-1:0] ew,
                                  input logic [wget_pkg::COUNT_W-1:0] cnt,
                                  input logic [wget_pkg::VERTEX_W-1:0] nb, input logic lst);
        wget_pkg::t_result r;
        r.status      = st;
        r.found       = fnd;
        r.edge_weight = ew;
        r.count       = cnt;
        r.neighbor    = nb;
        r.last        = lst;
        return r;
    endfunction

    function automatic logic vertex_ok(input logic [wget_pkg::VERTEX_W-1:0] v);
        return {1'b0, v} < vertices_used;
    endfunction

    task automatic reset_graph;
        int a;
        int b;
        for (a = 0; a < NV; a++) begin
            row_degree[a] = '0;
            for (b = 0; b < NV; b++) begin
                edge_on[a][b] = 1'b0;
                edge_wt[a][b] = '0;
            end
        end
        edge_total    = '0;
        mode_directed = 1'b0;
        vertices_used = wget_pkg::VCOUNT_RESET;
        due_results.delete();
        o_fail_count  = 0;
    endtask

    task automatic mark_edge(input logic [wget_pkg::VERTEX_W-1:0] s,
                             input logic [wget_pkg::VERTEX_W-1:0] d,
                             input logic [wget_pkg::IN_WEIGHT_W-1:0] w);
        if (!edge_on[s][d]) begin
            edge_on[s][d] = 1'b1;
            row_degree[s] = row_degree[s] + 7'd1;
        end
        edge_wt[s][d] = w;
    endtask

    task automatic unmark_edge(input logic [wget_pkg::VERTEX_W-1:0] s,
                               input logic [wget_pkg::VERTEX_W-1:0] d);
        if (edge_on[s][d]) begin
            edge_on[s][d] = 1'b0;
            if (row_degree[s] != 0)
                row_degree[s] = row_degree[s] - 7'd1;
        end
    endtask

    // Update the graph copy for one command and queue the results it causes
    task automatic apply_graph_command(input logic [wget_pkg::S_TDATA_W-1:0] item);
        logic [wget_pkg::CMD_W-1:0]        op;
        logic [wget_pkg::VERTEX_W-1:0]     s;
        logic [wget_pkg::VERTEX_W-1:0]     d;
        logic [wget_pkg::IN_WEIGHT_W-1:0]  w;
        logic                              had;
        int                                v;
        int                                last_nb;
        op  = item[2:0];
        s   = item[8:3];
        d   = item[14:9];
        w   = item[30:15];
        had = edge_on[s][d];
        if (op > wget_pkg::CMD_COUNT) begin
            // reserved codes are dropped without a result
        end else if (op == wget_pkg::CMD_COUNT) begin
            due_results.push_back(result_of(1'b0, 1'b0, '0, edge_total, '0, 1'b1));
        end else if (!vertex_ok(s) || (op <= wget_pkg::CMD_QUERY && !vertex_ok(d))) begin
            due_results.push_back(result_of(1'b1, 1'b0, '0, '0, '0, 1'b1));
        end else begin
            case (op)
                wget_pkg::CMD_ADD: begin
                    mark_edge(s, d, w);
                    if (!mode_directed && s != d)
                        mark_edge(d, s, w);
                    if (!had && edge_total != wget_pkg::TOTAL_MAX)
                        edge_total = edge_total + 13'd1;
                    due_results.push_back(result_of(1'b0, 1'b0, '0, '0, '0, 1'b1));
                end
                wget_pkg::CMD_REMOVE: begin
                    if (had) begin
                        unmark_edge(s, d);
                        if (!mode_directed && s != d)
                            unmark_edge(d, s);
                        if (edge_total != 0)
                            edge_total = edge_total - 13'd1;
                    end
                    due_results.push_back(result_of(1'b0, had, '0, '0, '0, 1'b1));
                end
                wget_pkg::CMD_QUERY: begin
                    due_results.push_back(result_of(1'b0, had,
                        had ? $signed({1'b0, edge_wt[s][d]}) : wget_pkg::NO_EDGE,
                        '0, '0, 1'b1));
                end
                wget_pkg::CMD_DEGREE: begin
                    due_results.push_back(result_of(1'b0, 1'b0, '0, {6'd0, row_degree[s]},
                                                    '0, 1'b1));
                end
                default: begin
                    // walk the row in ascending order, flag the highest neighbor as last
                    last_nb = -1;
                    for (v = 0; v < NV; v++)
                        if (edge_on[s][v])
                            last_nb = v;
                    if (last_nb < 0)
                        due_results.push_back(result_of(1'b0, 1'b0, '0, '0, '0, 1'b1));
                    for (v = 0; v < NV; v++)
                        if (edge_on[s][v])
                            due_results.push_back(result_of(1'b0, 1'b1, '0, '0, v[5:0],
                                                            v == last_nb));
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [wget_pkg::M_TDATA_W-1:0] want,
                               input logic [wget_pkg::M_TDATA_W-1:0] got);
        if (want !== got) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Compare result transfers, then take command and register transfers
    always @(posedge i_clk) begin
        wget_pkg::t_result want;
        if (!i_rst_n) begin
            reset_graph();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result with none due, expected nothing actual %h %b %b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end else begin
                    want = due_results.pop_front();
                    check_field("status", want.status, m_axis_tuser[0]);
                    check_field("found", want.found, m_axis_tuser[1]);
                    check_field("edge_weight", unsigned'(want.edge_weight),
                                m_axis_tdata[16:0]);
                    check_field("count", want.count, m_axis_tdata[29:17]);
                    check_field("neighbor", want.neighbor, m_axis_tdata[35:30]);
                    check_field("pad", '0, m_axis_tdata[39:36]);
                    check_field("last", want.last, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_graph_command(s_axis_tdata);
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    wget_pkg::REG_DIRECTED:     mode_directed = i_cfg_wdata[0];
                    wget_pkg::REG_VERTEX_COUNT: vertices_used = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
        o_results_due = due_results.size();
    end

endmodule

@@ dv/tb_weighted_graph_edge_table_core.sv @@
// Testbench top for weighted_graph_edge_table_core: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on wget_pkg and wget_edge_table_checker.
`timescale 1ns / 100ps

module tb_weighted_graph_edge_table_core;

    localparam int                         VW               = wget_pkg::VERTEX_W;
    localparam logic [wget_pkg::CMD_W-1:0] CMD_RSVD_A       = 3'd6;
    localparam logic [wget_pkg::CMD_W-1:0] CMD_RSVD_B       = 3'd7;
    localparam int                         RANDOM_PER_PHASE = 26;
    localparam int                         DRAIN_CYCLES     = 16;
    localparam int                         HOLD_CYCLES      = 300;

    logic                                i_clk;
    logic                                i_rst_n       = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [wget_pkg::S_TDATA_W-1:0]      s_axis_tdata  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [wget_pkg::M_TDATA_W-1:0]      m_axis_tdata;
    logic [wget_pkg::M_TUSER_W-1:0]      m_axis_tuser;
    logic                                m_axis_tlast;
    logic                                i_cfg_we      = 1'b0;
    logic [wget_pkg::CFG_ADDR_W-1:0]     i_cfg_addr    = wget_pkg::REG_DIRECTED;
    logic [wget_pkg::CFG_DATA_W-1:0]     i_cfg_wdata   = '0;

    int                      results_due;
    int                      fail_count;
    int                      send_idle_pct  = 0;
    int                      recv_stall_pct = 0;
    bit                      hold_req       = 1'b0;
    bit                      hold_done      = 1'b0;

    weighted_graph_edge_table_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    wget_edge_table_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_results_due (results_due),
        .o_fail_count  (fail_count)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        #20_000_000;
        $display("tb_weighted_graph_edge_table_core NOT OK");
        $finish;
    end

    // Result back-pressure: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one command and hold it until the transfer
    task automatic send_cmd(input logic [wget_pkg::CMD_W-1:0] op, input logic [VW-1:0] src,
                            input logic [VW-1:0] dst,
                            input logic [wget_pkg::IN_WEIGHT_W-1:0] wt);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, wt, dst, src, op};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every due result has come back
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (results_due != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input wget_pkg::t_cfg_reg idx,
                             input logic [wget_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly a small cluster of vertices so edges pile up; sometimes any index
    function automatic logic [VW-1:0] pick_vertex(input int vcnt);
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return VW'($urandom_range(63));
        if (r < 30)
            return VW'($urandom_range(vcnt - 1));
        return VW'($urandom_range((vcnt < 6 ? vcnt : 6) - 1));
    endfunction

    task automatic random_cmd(input int vcnt);
        int                                r;
        logic [wget_pkg::CMD_W-1:0]        op;
        logic [wget_pkg::IN_WEIGHT_W-1:0]  wt;
        r  = $urandom_range(99);
        op = (r < 35) ? wget_pkg::CMD_ADD : (r < 50) ? wget_pkg::CMD_REMOVE :
             (r < 65) ? wget_pkg::CMD_QUERY : (r < 75) ? wget_pkg::CMD_DEGREE :
             (r < 87) ? wget_pkg::CMD_LIST : (r < 95) ? wget_pkg::CMD_COUNT :
             (r < 97) ? CMD_RSVD_A : CMD_RSVD_B;
        r  = $urandom_range(99);
        wt = (r < 10) ? 16'h0000 : (r < 20) ? 16'hFFFF : 16'($urandom);
        send_cmd(op, pick_vertex(vcnt), pick_vertex(vcnt), wt);
    endtask

    task automatic run_phase(input logic dir, input logic [wget_pkg::CFG_DATA_W-1:0] vcnt,
                             input int idle, input int stall, input bit hold);
        write_reg(wget_pkg::REG_DIRECTED, {6'd0, dir});
        write_reg(wget_pkg::REG_VERTEX_COUNT, vcnt);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        if (hold)
            hold_req = 1'b1;
        repeat (RANDOM_PER_PHASE) random_cmd(vcnt);
        drain();
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(wget_pkg::REG_DIRECTED, 7'd0);
        write_reg(wget_pkg::REG_VERTEX_COUNT, 7'd64);

        // Undirected, all vertices: corner weights, mirroring, self loop, empty row
        send_cmd(wget_pkg::CMD_COUNT,  6'd0,  6'd0,  16'h0000);
        send_cmd(wget_pkg::CMD_LIST,   6'd0,  6'd0,  16'h0000);
        send_cmd(wget_pkg::CMD_ADD,    6'd0,  6'd63, 16'hFFFF);
        send_cmd(wget_pkg::CMD_ADD,    6'd63, 6'd0,  16'h0000);
        send_cmd(wget_pkg::CMD_QUERY,  6'd0,  6'd63, 16'h0000);
        send_cmd(wget_pkg::CMD_ADD,    6'd5,  6'd5,  16'h1234);
        send_cmd(wget_pkg::CMD_ADD,    6'd0,  6'd5,  16'h8001);
        send_cmd(wget_pkg::CMD_DEGREE, 6'd0,  6'd0,  16'h0000);
        send_cmd(wget_pkg::CMD_DEGREE, 6'd5,  6'd0,  16'h0000);
        send_cmd(wget_pkg::CMD_LIST,   6'd0,  6'd0,  16'h0000);
        send_cmd(wget_pkg::CMD_LIST,   6'd5,  6'd0,  16'h0000);
        send_cmd(wget_pkg::CMD_COUNT,  6'd0,  6'd0,  16'h0000);
        send_cmd(wget_pkg::CMD_REMOVE, 6'd0,  6'd63, 16'h0000);
        send_cmd(wget_pkg::CMD_REMOVE, 6'd63, 6'd0,  16'h0000);
        send_cmd(wget_pkg::CMD_QUERY,  6'd63, 6'd0,  16'h0000);
        send_cmd(CMD_RSVD_A,           6'd63, 6'd63, 16'hFFFF);
        send_cmd(CMD_RSVD_B,           6'd1,  6'd2,  16'h5555);
        drain();

        // One vertex, directed: range errors, and a row that keeps an out-of-range neighbor
        write_reg(wget_pkg::REG_DIRECTED, 7'd1);
        write_reg(wget_pkg::REG_VERTEX_COUNT, 7'd1);
        send_cmd(wget_pkg::CMD_ADD,    6'd0,  6'd0,  16'hFFFF);
        send_cmd(wget_pkg::CMD_ADD,    6'd1,  6'd0,  16'h00FF);
        send_cmd(wget_pkg::CMD_ADD,    6'd0,  6'd63, 16'h00FF);
        send_cmd(wget_pkg::CMD_QUERY,  6'd0,  6'd5,  16'h0000);
        send_cmd(wget_pkg::CMD_DEGREE, 6'd5,  6'd0,  16'h0000);
        send_cmd(wget_pkg::CMD_LIST,   6'd5,  6'd0,  16'h0000);
        send_cmd(wget_pkg::CMD_LIST,   6'd0,  6'd0,  16'h0000);
        send_cmd(wget_pkg::CMD_COUNT,  6'd63, 6'd63, 16'h0000);
        drain();

        // Random traffic across modes, sizes and flow-control patterns
        run_phase(1'b0, 7'd8,  0,  0,  1'b0);
        run_phase(1'b1, 7'd8,  61, 0,  1'b0);
        run_phase(1'b0, 7'd64, 0,  61, 1'b0);
        run_phase(1'b1, 7'd16, 26, 26, 1'b0);
        run_phase(1'b0, 7'd1,  0,  0,  1'b0);
        run_phase(1'b1, 7'd64, 0,  0,  1'b1);

        if (fail_count == 0)
            $display("tb_weighted_graph_edge_table_core OK");
        else
            $display("tb_weighted_graph_edge_table_core NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
hdl/wget_pkg.sv
hdl/wget_ctrl.sv
hdl/wget_dpath.sv
hdl/weighted_graph_edge_table_core.sv
dv/wget_edge_table_checker.sv
dv/tb_weighted_graph_edge_table_core.sv
